### design/lvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvc_pkg: shared types and constants for the line viewport clipper
// Outcode bits, clip edge codes, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package lvc_pkg;

  localparam int FRAME_BITS = 13;
  localparam int CLIP_BITS  = 12;

  // region outcode bits
  localparam logic [3:0] OC_LEFT   = 4'd1;
  localparam logic [3:0] OC_RIGHT  = 4'd2;
  localparam logic [3:0] OC_BOTTOM = 4'd4;
  localparam logic [3:0] OC_TOP    = 4'd8;

  localparam logic [3:0] CLIP_STEP_LIMIT = 4'd8;

  localparam logic [FRAME_BITS-1:0] VIEW_MAX      = 13'd4096;
  localparam logic [FRAME_BITS-1:0] RESET_WIDTH   = 13'd640;
  localparam logic [FRAME_BITS-1:0] RESET_HEIGHT  = 13'd480;

  // configuration register indexes
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    EDGE_TOP,
    EDGE_BOTTOM,
    EDGE_RIGHT,
    EDGE_LEFT
  } clip_edge_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CODE,
    ST_SETUP,
    ST_WAIT,
    ST_DONE
  } lvc_state_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_PREP,
    MD_MUL,
    MD_DIV,
    MD_DONE
  } md_state_t;

endpackage

### design/lvc_muldiv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvc_muldiv: iterative signed a * n / d
// One shared adder does shift-add multiply, then restoring division,
// quotient truncated toward zero, zero divisor gives zero.
// ----------------------------------------------------------------------------
module lvc_muldiv import lvc_pkg::*; #(
  parameter int DATA_BITS = 17
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [DATA_BITS-1:0] mul_a,
  input  logic signed [DATA_BITS-1:0] mul_n,
  input  logic signed [DATA_BITS-1:0] div_d,
  output logic                        done,
  output logic signed [DATA_BITS-1:0] quot
);

  localparam int CW = $clog2(DATA_BITS);

  md_state_t state, state_next;

  logic [DATA_BITS-1:0] ua, ud, hi, lo;
  logic                 neg, dz;
  logic [CW-1:0]        cnt;

  logic [DATA_BITS+1:0] op_x, op_y, sum;
  logic                 is_mul, fits;

  // shared adder: add multiplicand in multiply, subtract divisor in divide
  always_comb begin
    is_mul = (state == MD_MUL);
    if (is_mul) begin
      op_x = {2'b00, hi};
      op_y = lo[0] ? {2'b00, ua} : '0;
    end else begin
      op_x = {1'b0, hi, lo[DATA_BITS-1]};
      op_y = ~{2'b00, ud};
    end
    sum  = op_x + op_y + {{(DATA_BITS+1){1'b0}}, ~is_mul};
    fits = ~sum[DATA_BITS+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      MD_IDLE: begin
        if (start) begin
          ua  <= mul_a;
          lo  <= mul_n;
          ud  <= div_d;
          neg <= mul_a[DATA_BITS-1] ^ mul_n[DATA_BITS-1] ^ div_d[DATA_BITS-1];
        end
      end
      MD_PREP: begin
        ua  <= ua[DATA_BITS-1] ? -ua : ua;
        lo  <= lo[DATA_BITS-1] ? -lo : lo;
        ud  <= ud[DATA_BITS-1] ? -ud : ud;
        dz  <= (ud == '0);
        hi  <= '0;
        cnt <= CW'(DATA_BITS - 1);
      end
      MD_MUL: begin
        hi  <= sum[DATA_BITS:1];
        lo  <= {sum[0], lo[DATA_BITS-1:1]};
        cnt <= (cnt == '0) ? CW'(DATA_BITS - 1) : cnt - 1'b1;
      end
      MD_DIV: begin
        hi  <= fits ? sum[DATA_BITS-1:0] : {hi[DATA_BITS-2:0], lo[DATA_BITS-1]};
        lo  <= {lo[DATA_BITS-2:0], fits};
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      MD_IDLE: if (start) state_next = MD_PREP;
      MD_PREP: state_next = MD_MUL;
      MD_MUL:  if (cnt == '0) state_next = MD_DIV;
      MD_DIV:  if (cnt == '0) state_next = MD_DONE;
      MD_DONE: state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == MD_DONE);
    if (dz) begin
      quot = '0;
    end else if (neg) begin
      quot = -signed'(lo);
    end else begin
      quot = signed'(lo);
    end
  end

endmodule

### design/line_viewport_clipper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_viewport_clipper: Cohen-Sutherland clipping of one segment
// Clips a segment with signed endpoints to the viewport 0..width-1 by
// 0..height-1 and returns an accept flag with the clipped endpoints.
// ----------------------------------------------------------------------------
// One segment is handled at a time. Each edge move passes through the code,
// setup and wait states, and a segment needs at most four moves in practice
// and at most eight, after which it is rejected unless both endpoints then
// lie inside. The wait lasts until the shared multiply/divide unit is done;
// it spends one cycle per bit of the (COORD_BITS + 1)-bit product half and
// of the quotient. The result sits in an output register, so the next
// segment can be taken while it waits.
// Zero width or height rejects every segment; sizes above 4096 act as 4096.
// Intersections truncate toward zero. Rejected results carry zero
// coordinates. Configuration writes are always taken (cfg_ready is tied high).
module line_viewport_clipper import lvc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // segment input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] start_x,
  input  logic signed [COORD_BITS-1:0] start_y,
  input  logic signed [COORD_BITS-1:0] end_x,
  input  logic signed [COORD_BITS-1:0] end_y,
  // clipped result
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         accepted,
  output logic [CLIP_BITS-1:0]         clip_start_x,
  output logic [CLIP_BITS-1:0]         clip_start_y,
  output logic [CLIP_BITS-1:0]         clip_end_x,
  output logic [CLIP_BITS-1:0]         clip_end_y,
  // configuration writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [FRAME_BITS-1:0]        cfg_data
);

  localparam int DW  = COORD_BITS + 1;
  localparam int PAD = COORD_BITS - CLIP_BITS;

  lvc_state_t state, state_next;

  // configuration registers
  logic [FRAME_BITS-1:0] frame_width, frame_height;

  // working segment and viewport limits latched per segment
  logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [CLIP_BITS-1:0]         xmax, ymax;
  logic                         view_empty;
  logic [3:0]                   steps;
  logic                         sel_start;
  clip_edge_t                   clip_edge, clip_edge_next;

  // handshake and sequencer controls
  logic in_xfer, out_xfer, load_out, md_start, md_done;
  logic settled, seg_accept;

  // viewport size after saturation
  logic [FRAME_BITS-1:0] w_sat, h_sat, w_m1, h_m1;

  // outcodes and operands
  logic [3:0]                   c0, c1, code_sel;
  logic signed [COORD_BITS-1:0] xmax_c, ymax_c;
  logic signed [DW-1:0]         sx_w, sy_w, ex_w, ey_w, xmax_w, ymax_w, dx, dy;
  logic signed [DW-1:0]         op_a, op_n, op_d, md_quot;
  logic signed [DW-1:0]         base_sum;
  logic signed [COORD_BITS-1:0] new_x, new_y;

  function automatic logic [3:0] outcode(
    input logic signed [COORD_BITS-1:0] x,
    input logic signed [COORD_BITS-1:0] y,
    input logic signed [COORD_BITS-1:0] xm,
    input logic signed [COORD_BITS-1:0] ym
  );
    logic [3:0] c;
    c = '0;
    if (x < 0) begin
      c = c | OC_LEFT;
    end else if (x > xm) begin
      c = c | OC_RIGHT;
    end
    if (y < 0) begin
      c = c | OC_BOTTOM;
    end else if (y > ym) begin
      c = c | OC_TOP;
    end
    return c;
  endfunction

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    w_sat = (frame_width > VIEW_MAX) ? VIEW_MAX : frame_width;
    h_sat = (frame_height > VIEW_MAX) ? VIEW_MAX : frame_height;
    w_m1  = w_sat - FRAME_BITS'(1);
    h_m1  = h_sat - FRAME_BITS'(1);
  end

  // ---------------------------------------------------------------------------
  // outcodes, differences and intersection operands
  // ---------------------------------------------------------------------------
  always_comb begin
    xmax_c = signed'({{PAD{1'b0}}, xmax});
    ymax_c = signed'({{PAD{1'b0}}, ymax});
    xmax_w = signed'({{(PAD + 1){1'b0}}, xmax});
    ymax_w = signed'({{(PAD + 1){1'b0}}, ymax});
    sx_w   = DW'(sx);
    sy_w   = DW'(sy);
    ex_w   = DW'(ex);
    ey_w   = DW'(ey);
    dx     = ex_w - sx_w;
    dy     = ey_w - sy_w;
    c0     = outcode(sx, sy, xmax_c, ymax_c);
    c1     = outcode(ex, ey, xmax_c, ymax_c);

    // both inside, or trivially outside, or out of moves, or empty view
    settled    = view_empty || ((c0 | c1) == 4'd0) || ((c0 & c1) != 4'd0)
                 || (steps >= CLIP_STEP_LIMIT);
    seg_accept = !view_empty && ((c0 | c1) == 4'd0);

    // first outside endpoint picks the edge: top, bottom, right, left
    code_sel = (c0 != 4'd0) ? c0 : c1;
    if ((code_sel & OC_TOP) != 4'd0) begin
      clip_edge_next = EDGE_TOP;
    end else if ((code_sel & OC_BOTTOM) != 4'd0) begin
      clip_edge_next = EDGE_BOTTOM;
    end else if ((code_sel & OC_RIGHT) != 4'd0) begin
      clip_edge_next = EDGE_RIGHT;
    end else begin
      clip_edge_next = EDGE_LEFT;
    end
  end

  // other = s_other + trunc(d_other * (edge - s_this) / d_this)
  always_comb begin
    case (clip_edge)
      EDGE_TOP: begin
        op_a = dx;
        op_n = ymax_w - sy_w;
        op_d = dy;
      end
      EDGE_BOTTOM: begin
        op_a = dx;
        op_n = -sy_w;
        op_d = dy;
      end
      EDGE_RIGHT: begin
        op_a = dy;
        op_n = xmax_w - sx_w;
        op_d = dx;
      end
      default: begin
        op_a = dy;
        op_n = -sx_w;
        op_d = dx;
      end
    endcase
  end

  lvc_muldiv #(
    .DATA_BITS (DW)
  ) u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (md_start),
    .mul_a (op_a),
    .mul_n (op_n),
    .div_d (op_d),
    .done  (md_done),
    .quot  (md_quot)
  );

  // new endpoint: one coordinate on the edge, the other from the quotient
  always_comb begin
    if (clip_edge == EDGE_TOP || clip_edge == EDGE_BOTTOM) begin
      base_sum = sx_w + md_quot;
      new_x    = base_sum[COORD_BITS-1:0];
      new_y    = (clip_edge == EDGE_TOP) ? ymax_c : '0;
    end else begin
      base_sum = sy_w + md_quot;
      new_y    = base_sum[COORD_BITS-1:0];
      new_x    = (clip_edge == EDGE_RIGHT) ? xmax_c : '0;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer) state_next = ST_CODE;
      ST_CODE:  state_next = settled ? ST_DONE : ST_SETUP;
      ST_SETUP: state_next = ST_WAIT;
      ST_WAIT:  if (md_done) state_next = ST_CODE;
      ST_DONE:  if (!out_valid || out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    md_start = (state == ST_SETUP);
    load_out = (state == ST_DONE) && (!out_valid || out_ready);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sx         <= start_x;
      sy         <= start_y;
      ex         <= end_x;
      ey         <= end_y;
      xmax       <= w_m1[CLIP_BITS-1:0];
      ymax       <= h_m1[CLIP_BITS-1:0];
      view_empty <= (frame_width == '0) || (frame_height == '0);
      steps      <= '0;
    end else if (state == ST_CODE) begin
      sel_start <= (c0 != 4'd0);
      clip_edge <= clip_edge_next;
    end else if (state == ST_WAIT && md_done) begin
      steps <= steps + 4'd1;
      if (sel_start) begin
        sx <= new_x;
        sy <= new_y;
      end else begin
        ex <= new_x;
        ey <= new_y;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      accepted     <= seg_accept;
      clip_start_x <= seg_accept ? sx[CLIP_BITS-1:0] : '0;
      clip_start_y <= seg_accept ? sy[CLIP_BITS-1:0] : '0;
      clip_end_x   <= seg_accept ? ex[CLIP_BITS-1:0] : '0;
      clip_end_y   <= seg_accept ? ey[CLIP_BITS-1:0] : '0;
    end
  end

`ifndef SYNTHESIS
  // a rejected segment reports all coordinates as zero
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !accepted |-> (clip_start_x == '0) && (clip_start_y == '0)
      && (clip_end_x == '0) && (clip_end_y == '0))
    else $error("rejected result with nonzero coordinates");

  // the move count never passes the limit
  a_step_limit: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> steps <= CLIP_STEP_LIMIT)
    else $error("clip move count above limit");

  // a start moved to the top edge lands on the top row
  a_top_move: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT && md_done && clip_edge == EDGE_TOP && sel_start
      |=> sy == ymax_c)
    else $error("top edge move missed the edge");

  // the divide unit finishes only while the sequencer waits on it
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    md_done |-> state == ST_WAIT)
    else $error("divide result outside wait state");
`endif

endmodule
